@@ rtl/ctt_pkg.sv @@
`default_nettype none
package ctt_pkg;
	localparam int NUM_BUCKETS_DEF = 4096;
	localparam int WAYS_DEF = 4;
	localparam int KEY_W = 64;
	localparam int DEPTH_W = 8;
	localparam int SCORE_W = 16;
	localparam int FLAG_W = 2;
	localparam int MOVE_W = 16;
	localparam int PLY_W = 7;
	localparam int AGE_W = 15;
	localparam int THR_W = 15;
	localparam logic [AGE_W-1:0] AGE_MAX = 15'd32767;
	localparam logic signed [DEPTH_W-1:0] EMPTY_DEPTH = 8'sh80;
	localparam logic [THR_W-1:0] THR_RESET = 15'd30000;

	typedef enum logic [1:0] {
		CMD_PROBE = 2'd0,
		CMD_STORE = 2'd1,
		CMD_NEWGEN = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic signed [DEPTH_W-1:0] depth;
		logic signed [SCORE_W-1:0] score;
		logic signed [SCORE_W-1:0] stat;
		logic signed [SCORE_W-1:0] marg;
		logic [FLAG_W-1:0] flag;
		logic [MOVE_W-1:0] move;
	} ent_t;
endpackage
`default_nettype wire

@@ rtl/clustered_transposition_table.sv @@
// Probe and store scan the WAYS entries of one bucket; when NUM_BUCKETS is not a power of two,
// a radix-16 reduction of the key modulo NUM_BUCKETS comes first. The way scan reads one
// entry per cycle from the table memory and stops early on a hit, a match or an empty way.
// New generation raises done straight from idle unless the age wraps, when a sweep resets every
// age; clear sweeps the whole table. Reset runs a clearing pass over all NUM_BUCKETS + WAYS
// entries with busy high and no done. One done strobe per command; the receiver cannot stall.
`default_nettype none
module clustered_transposition_table
	import ctt_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int WAYS = WAYS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] cmd,
	input wire logic [KEY_W-1:0] hash_key,
	input wire logic signed [DEPTH_W-1:0] search_depth,
	input wire logic signed [SCORE_W-1:0] score,
	input wire logic signed [SCORE_W-1:0] static_score,
	input wire logic signed [SCORE_W-1:0] score_margin,
	input wire logic [FLAG_W-1:0] bound_flag,
	input wire logic [MOVE_W-1:0] best_move,
	input wire logic [PLY_W-1:0] ply_from_root,
	input wire logic cfg_we,
	input wire logic [THR_W-1:0] cfg_wdata,
	output logic done,
	output logic hit,
	output logic signed [DEPTH_W-1:0] found_depth,
	output logic signed [SCORE_W-1:0] found_score,
	output logic signed [SCORE_W-1:0] found_static,
	output logic signed [SCORE_W-1:0] found_margin,
	output logic [FLAG_W-1:0] found_flag,
	output logic [MOVE_W-1:0] found_move
);
	localparam int TS = NUM_BUCKETS + WAYS;
	localparam int AW = $clog2(TS);
	localparam int BW = $clog2(NUM_BUCKETS);
	localparam int CW = $clog2(WAYS + 1);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam bit POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

	typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_SCAN, ST_SWEEP} state_t;

	state_t st_q;
	cmd_t cmd_q;
	logic [KEY_W-1:0] key_q;
	logic signed [DEPTH_W-1:0] dep_q;
	logic signed [SCORE_W-1:0] sc_q, stat_q, marg_q;
	logic [FLAG_W-1:0] flag_q;
	logic [MOVE_W-1:0] move_q;
	logic [PLY_W-1:0] ply_q;
	logic [BW-1:0] base_q, rem_q;
	logic [3:0] dig_q;
	logic [CW-1:0] iss_q;
	logic rd_vld_s1;
	logic [WW-1:0] way_s1, sel_q;
	logic [AGE_W-1:0] sel_age_q, gen_q;
	logic signed [DEPTH_W-1:0] sel_dep_q;
	logic [THR_W-1:0] mt_q;
	logic [AW-1:0] swp_q;
	logic swp_all_q, swp_res_q;

	ent_t main_mem [TS];
	logic [AGE_W-1:0] age_mem [TS];
	ent_t ent_s1;
	logic [AGE_W-1:0] age_s1;

	logic rd_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic main_we, age_we;
	ent_t wr_data;
	logic [AGE_W-1:0] age_wdata;

	logic [BW+3:0] mod_t, mod_r, mod_sub;
	logic ent_empty, ent_match, ent_last, ent_better, fin, fin_hit;
	logic [WW-1:0] wway, nsel;
	logic signed [17:0] sx, thr18, sv;
	logic signed [16:0] ps, pthr;
	logic signed [SCORE_W-1:0] sat_score, adj_score;

	assign busy = (st_q != ST_IDLE);

	assign mod_t = {rem_q, key_q[{~dig_q, 2'b11} -: 4]};

	always_comb begin
		mod_sub = '0;
		for (int k = 1; k < 16; k++) begin
			if (mod_t >= (BW+4)'(k * NUM_BUCKETS)) begin
				mod_sub = (BW+4)'(k * NUM_BUCKETS);
			end
		end
		mod_r = mod_t - mod_sub;
	end

	assign rd_en = (st_q == ST_SCAN) && (iss_q < CW'(WAYS));
	assign rd_addr = AW'(base_q) + AW'(iss_q);

	always_comb begin
		sx = 18'(sc_q);
		thr18 = {3'b000, mt_q};
		if (sx >= thr18) begin
			sv = sx + 18'(ply_q);
		end else if (sx <= -thr18) begin
			sv = sx - 18'(ply_q);
		end else begin
			sv = sx;
		end
		if (sv > 18'sd32767) begin
			sat_score = 16'sh7fff;
		end else if (sv < -18'sd32768) begin
			sat_score = 16'sh8000;
		end else begin
			sat_score = sv[15:0];
		end
		ps = 17'(ent_s1.score);
		pthr = {2'b00, mt_q};
		if (ps > pthr) begin
			adj_score = 16'(ps - 17'(ply_q));
		end else if (ps < -pthr) begin
			adj_score = 16'(ps + 17'(ply_q));
		end else begin
			adj_score = ent_s1.score;
		end
	end

	always_comb begin
		ent_empty = (ent_s1.depth == EMPTY_DEPTH);
		ent_match = !ent_empty && (ent_s1.key == key_q);
		ent_last = (way_s1 == WW'(WAYS - 1));
		ent_better = (way_s1 == '0) || (age_s1 < sel_age_q) || (ent_s1.depth < sel_dep_q);
		nsel = ent_better ? way_s1 : sel_q;
		fin = 1'b0;
		fin_hit = 1'b0;
		main_we = 1'b0;
		age_we = 1'b0;
		wway = way_s1;
		wr_addr = swp_q;
		wr_data = '0;
		wr_data.depth = EMPTY_DEPTH;
		age_wdata = '0;
		if (st_q == ST_SWEEP) begin
			main_we = swp_all_q;
			age_we = 1'b1;
		end else if (st_q == ST_SCAN && rd_vld_s1) begin
			if (cmd_q == CMD_PROBE) begin
				fin_hit = ent_match;
				fin = ent_match || ent_last;
			end else if (ent_match && ent_s1.depth > dep_q) begin
				fin = 1'b1;
			end else if (ent_match || ent_empty) begin
				fin = 1'b1;
				main_we = 1'b1;
			end else if (ent_last) begin
				fin = 1'b1;
				main_we = 1'b1;
				wway = nsel;
			end
			age_we = main_we;
			wr_addr = AW'(base_q) + AW'(wway);
			wr_data = '{key: key_q, depth: dep_q, score: sat_score, stat: stat_q,
				marg: marg_q, flag: flag_q, move: move_q};
			age_wdata = gen_q;
		end
	end

	always_ff @(posedge clk) begin
		if (main_we) begin
			main_mem[wr_addr] <= wr_data;
		end
		if (age_we) begin
			age_mem[wr_addr] <= age_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_s1 <= main_mem[rd_addr];
			age_s1 <= age_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_SWEEP;
			swp_q <= '0;
			swp_all_q <= 1'b1;
			swp_res_q <= 1'b0;
			gen_q <= '0;
			mt_q <= THR_RESET;
			rd_vld_s1 <= 1'b0;
			done <= 1'b0;
			hit <= 1'b0;
			found_depth <= '0;
			found_score <= '0;
			found_static <= '0;
			found_margin <= '0;
			found_flag <= '0;
			found_move <= '0;
		end else begin
			done <= 1'b0;
			hit <= 1'b0;
			found_depth <= '0;
			found_score <= '0;
			found_static <= '0;
			found_margin <= '0;
			found_flag <= '0;
			found_move <= '0;
			if (cfg_we) begin
				mt_q <= cfg_wdata;
			end
			case (st_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (start) begin
						cmd_q <= cmd_t'(cmd);
						key_q <= hash_key;
						dep_q <= search_depth;
						sc_q <= score;
						stat_q <= static_score;
						marg_q <= score_margin;
						flag_q <= bound_flag;
						move_q <= best_move;
						ply_q <= ply_from_root;
						iss_q <= '0;
						rem_q <= '0;
						dig_q <= '0;
						swp_q <= '0;
						swp_res_q <= 1'b1;
						case (cmd_t'(cmd))
							CMD_PROBE, CMD_STORE: begin
								if (POW2) begin
									base_q <= hash_key[BW-1:0];
									st_q <= ST_SCAN;
								end else begin
									st_q <= ST_MOD;
								end
							end
							CMD_NEWGEN: begin
								if (gen_q == AGE_MAX) begin
									gen_q <= AGE_W'(1);
									swp_all_q <= 1'b0;
									st_q <= ST_SWEEP;
								end else begin
									gen_q <= gen_q + AGE_W'(1);
									done <= 1'b1;
								end
							end
							default: begin
								gen_q <= '0;
								swp_all_q <= 1'b1;
								st_q <= ST_SWEEP;
							end
						endcase
					end
				end
				ST_MOD: begin
					rem_q <= mod_r[BW-1:0];
					dig_q <= dig_q + 4'd1;
					if (dig_q == 4'd15) begin
						base_q <= mod_r[BW-1:0];
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						way_s1 <= WW'(iss_q);
						iss_q <= iss_q + CW'(1);
					end
					if (rd_vld_s1) begin
						sel_q <= nsel;
						if (ent_better) begin
							sel_age_q <= age_s1;
							sel_dep_q <= ent_s1.depth;
						end
					end
					if (fin) begin
						st_q <= ST_IDLE;
						rd_vld_s1 <= 1'b0;
						done <= 1'b1;
						if (fin_hit) begin
							hit <= 1'b1;
							found_depth <= ent_s1.depth;
							found_score <= adj_score;
							found_static <= ent_s1.stat;
							found_margin <= ent_s1.marg;
							found_flag <= ent_s1.flag;
							found_move <= ent_s1.move;
						end
					end
				end
				ST_SWEEP: begin
					swp_q <= swp_q + AW'(1);
					if (swp_q == AW'(TS - 1)) begin
						st_q <= ST_IDLE;
						done <= swp_res_q;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n) hit |-> done)
		else $error("hit without done");
	a_probe_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN && cmd_q == CMD_PROBE) |-> !main_we)
		else $error("probe wrote the table");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		main_we |-> (wr_addr <= AW'(TS - 1)))
		else $error("write beyond table");
	a_sweep_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SWEEP) |-> !rd_en)
		else $error("read during sweep");
endmodule
`default_nettype wire

@@ tb/clustered_transposition_table_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module clustered_transposition_table_tb;
	import ctt_pkg::*;

	localparam int BUCKETS = NUM_BUCKETS_DEF;
	localparam int NWAYS = WAYS_DEF;
	localparam int SLOTS = BUCKETS + NWAYS;

	typedef struct {
		cmd_t op;
		logic [KEY_W-1:0] key;
		logic signed [DEPTH_W-1:0] depth;
		logic signed [SCORE_W-1:0] score;
		logic signed [SCORE_W-1:0] stat;
		logic signed [SCORE_W-1:0] marg;
		logic [FLAG_W-1:0] flag;
		logic [MOVE_W-1:0] move;
		logic [PLY_W-1:0] ply;
	} cmd_item_t;

	typedef struct {
		logic hit;
		logic signed [DEPTH_W-1:0] depth;
		logic signed [SCORE_W-1:0] score;
		logic signed [SCORE_W-1:0] stat;
		logic signed [SCORE_W-1:0] marg;
		logic [FLAG_W-1:0] flag;
		logic [MOVE_W-1:0] move;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic [KEY_W-1:0] hash_key = '0;
	logic signed [DEPTH_W-1:0] search_depth = '0;
	logic signed [SCORE_W-1:0] score = '0;
	logic signed [SCORE_W-1:0] static_score = '0;
	logic signed [SCORE_W-1:0] score_margin = '0;
	logic [FLAG_W-1:0] bound_flag = '0;
	logic [MOVE_W-1:0] best_move = '0;
	logic [PLY_W-1:0] ply_from_root = '0;
	logic cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;
	logic done;
	logic hit;
	logic signed [DEPTH_W-1:0] found_depth;
	logic signed [SCORE_W-1:0] found_score;
	logic signed [SCORE_W-1:0] found_static;
	logic signed [SCORE_W-1:0] found_margin;
	logic [FLAG_W-1:0] found_flag;
	logic [MOVE_W-1:0] found_move;

	clustered_transposition_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.hash_key(hash_key), .search_depth(search_depth), .score(score),
		.static_score(static_score), .score_margin(score_margin),
		.bound_flag(bound_flag), .best_move(best_move), .ply_from_root(ply_from_root),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .hit(hit),
		.found_depth(found_depth), .found_score(found_score),
		.found_static(found_static), .found_margin(found_margin),
		.found_flag(found_flag), .found_move(found_move)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow table
	logic [KEY_W-1:0] sh_key[SLOTS];
	int sh_depth[SLOTS];
	int sh_score[SLOTS];
	int sh_stat[SLOTS];
	int sh_marg[SLOTS];
	int sh_flag[SLOTS];
	int sh_move[SLOTS];
	int sh_age[SLOTS];
	int sh_gen;
	int mate_thr;

	cmd_item_t pending[$];
	lookup_t lookups_due[$];
	int errors = 0;
	int idle_left = 0;
	bit quiet = 0;
	cmd_item_t cur;

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			sh_depth[i] = -128;
			sh_age[i] = 0;
		end
		sh_gen = 0;
	endfunction

	function automatic lookup_t run_command(cmd_item_t it);
		lookup_t r;
		int base, sel, v, s;
		bit skip;
		r = '{default: '0};
		base = int'(it.key % BUCKETS);
		case (it.op)
			CMD_PROBE: begin
				for (int i = 0; i < NWAYS; i++) begin
					if (sh_depth[base+i] != -128 && sh_key[base+i] == it.key) begin
						s = sh_score[base+i];
						if (s > mate_thr) s -= it.ply;
						else if (s < -mate_thr) s += it.ply;
						r.hit = 1'b1;
						r.depth = DEPTH_W'(sh_depth[base+i]);
						r.score = SCORE_W'(s);
						r.stat = SCORE_W'(sh_stat[base+i]);
						r.marg = SCORE_W'(sh_marg[base+i]);
						r.flag = FLAG_W'(sh_flag[base+i]);
						r.move = MOVE_W'(sh_move[base+i]);
						break;
					end
				end
			end
			CMD_STORE: begin
				sel = base;
				skip = 0;
				for (int i = 0; i < NWAYS; i++) begin
					if (sh_depth[base+i] != -128 && sh_key[base+i] == it.key) begin
						if (sh_depth[base+i] > int'(it.depth)) skip = 1;
						sel = base + i;
						break;
					end
					if (sh_depth[base+i] == -128) begin
						sel = base + i;
						break;
					end
					if (i > 0 && (sh_age[base+i] < sh_age[sel] ||
							sh_depth[base+i] < sh_depth[sel]))
						sel = base + i;
				end
				if (!skip) begin
					v = int'(it.score);
					if (v >= mate_thr) v += it.ply;
					else if (v <= -mate_thr) v -= it.ply;
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
					sh_key[sel] = it.key;
					sh_depth[sel] = int'(it.depth);
					sh_score[sel] = v;
					sh_stat[sel] = int'(it.stat);
					sh_marg[sel] = int'(it.marg);
					sh_flag[sel] = int'(it.flag);
					sh_move[sel] = int'(it.move);
					sh_age[sel] = sh_gen;
				end
			end
			CMD_NEWGEN: begin
				if (sh_gen >= 32767) begin
					for (int i = 0; i < SLOTS; i++) sh_age[i] = 0;
					sh_gen = 1;
				end else sh_gen++;
			end
			default: wipe_table();
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				lookups_due.push_back(run_command(cur));
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					start <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					cmd <= cur.op;
					hash_key <= cur.key;
					search_depth <= cur.depth;
					score <= cur.score;
					static_score <= cur.stat;
					score_margin <= cur.marg;
					bound_flag <= cur.flag;
					best_move <= cur.move;
					ply_from_root <= cur.ply;
					start <= 1'b1;
					if (!quiet && $urandom_range(3) == 0)
						idle_left <= $urandom_range(6, 1);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		lookup_t w;
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual hit=%0b", $time, hit);
				errors++;
			end else begin
				w = lookups_due.pop_front();
				check_field("hit", w.hit, hit);
				check_field("found_depth", w.depth, found_depth);
				check_field("found_score", w.score, found_score);
				check_field("found_static", w.stat, found_static);
				check_field("found_margin", w.marg, found_margin);
				check_field("found_flag", w.flag, found_flag);
				check_field("found_move", w.move, found_move);
			end
		end
	end

	function automatic cmd_item_t mk(cmd_t op, logic [63:0] key, int d, int sc, int st,
			int mg, int fl, int mv, int ply);
		cmd_item_t it;
		it.op = op;
		it.key = key;
		it.depth = DEPTH_W'(d);
		it.score = SCORE_W'(sc);
		it.stat = SCORE_W'(st);
		it.marg = SCORE_W'(mg);
		it.flag = FLAG_W'(fl);
		it.move = MOVE_W'(mv);
		it.ply = PLY_W'(ply);
		return it;
	endfunction

	function automatic logic [63:0] pick_key();
		logic [63:0] hi;
		int b;
		case ($urandom_range(5))
			0: b = 0;
			1: b = BUCKETS - 1;
			2: b = 100 + $urandom_range(5);
			3: b = $urandom_range(BUCKETS - 1);
			default: b = 500 + $urandom_range(3);
		endcase
		case ($urandom_range(3))
			0: hi = {$urandom, $urandom};
			1: hi = '1;
			default: hi = $urandom_range(3);
		endcase
		return {hi[63:12], 12'(b)};
	endfunction

	function automatic int pick_score();
		case ($urandom_range(4))
			0: return mate_thr + $urandom_range(6) - 3;
			1: return -mate_thr + $urandom_range(6) - 3;
			2: return $urandom_range(1) ? 32767 - $urandom_range(130) : -32768 + $urandom_range(130);
			default: return $signed(16'($urandom));
		endcase
	endfunction

	function automatic cmd_item_t random_cmd();
		int r;
		cmd_t op;
		r = $urandom_range(99);
		op = r < 46 ? CMD_PROBE : r < 92 ? CMD_STORE : r < 98 ? CMD_NEWGEN : CMD_CLEAR;
		return mk(op, pick_key(), $urandom_range(5) == 0 ? -128 + $urandom_range(1) :
			$signed(8'($urandom_range(20) - 10 + ($urandom_range(1) ? 0 : 100))),
			pick_score(), $signed(16'($urandom)), $signed(16'($urandom)),
			$urandom_range(3), $urandom_range(65535), $urandom_range(127));
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (pending.size() > 0 || start || lookups_due.size() > 0 || busy);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_threshold(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= THR_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		mate_thr = v;
	endtask

	initial begin
		int thr_list[4];
		logic [63:0] k0;
		thr_list = '{0, 32767, 30000, 0};
		wipe_table();
		mate_thr = 30000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		drain();
		k0 = 64'hDEAD_BEEF_0000_0007;
		pending.push_back(mk(CMD_PROBE, k0, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_STORE, k0, 5, 30000, 32767, -32768, 3, 65535, 127));
		pending.push_back(mk(CMD_PROBE, k0, 0, 0, 0, 0, 0, 0, 127));
		pending.push_back(mk(CMD_STORE, k0, 4, 1, 2, 3, 1, 4, 0));
		pending.push_back(mk(CMD_STORE, k0, 5, -30000, -1, 1, 2, 9, 127));
		pending.push_back(mk(CMD_PROBE, k0, 0, 0, 0, 0, 0, 0, 100));
		pending.push_back(mk(CMD_STORE, '1, 127, 32767, 0, 0, 0, 0, 127));
		pending.push_back(mk(CMD_STORE, 64'h0, -127, -32768, 0, 0, 0, 0, 127));
		for (int i = 1; i <= 5; i++)
			pending.push_back(mk(CMD_STORE, {52'(i), 12'd7}, i, i, i, i, i, i, 0));
		pending.push_back(mk(CMD_NEWGEN, 0, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_STORE, {52'd9, 12'd7}, 3, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_PROBE, {52'd1, 12'd7}, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_PROBE, '1, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_STORE, {52'd3, 12'd9}, -128, 7, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_PROBE, {52'd3, 12'd9}, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(CMD_PROBE, k0, 0, 0, 0, 0, 0, 0, 0));
		drain();
		foreach (thr_list[p]) begin
			set_threshold(p == 3 ? $urandom_range(32767) : thr_list[p]);
			for (int i = 0; i < 85; i++) pending.push_back(random_cmd());
			drain();
		end
		// no idling
		quiet = 1;
		for (int i = 0; i < 40; i++) begin
			pending.push_back(random_cmd());
			if (pending[$].op == CMD_CLEAR) pending[$].op = CMD_STORE;
		end
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/ctt_pkg.sv
rtl/clustered_transposition_table.sv
tb/clustered_transposition_table_tb.sv
